// ===== hw/rtl/montgomery_mul_256_cios_defines.svh =====
// ----------------------------------------------------------------------------
// montgomery_mul_256_cios_defines.svh
// Assertion macros for the Montgomery multiplier RTL.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_MUL_256_CIOS_DEFINES_SVH
`define MONTGOMERY_MUL_256_CIOS_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MMC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmc assertion failed");

// Next-cycle implication, disabled while in reset.
`define MMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmc assertion failed");

`endif

// ===== hw/rtl/mmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_pkg
// Widths, reset constants and types for the 256-bit Montgomery multiplier.
// ----------------------------------------------------------------------------
package mmc_pkg;

    localparam int LIMB_W    = 64;
    localparam int HALF_W    = 32;
    localparam int NUM_LIMBS = 4;
    localparam int WORD_W    = LIMB_W * NUM_LIMBS;   // 256
    // Accumulator between rounds stays below 2^258
    localparam int T_W       = WORD_W + 2;
    // Widest intermediate sum (acc + u*m) stays below 2^322
    localparam int ACC_W     = WORD_W + LIMB_W + 2;
    localparam int CFG_IDX_W = 3;

    // P-256 prime and its -m^-1 mod 2^64
    localparam logic [WORD_W-1:0] MOD_RESET = {
        64'hffffffff00000001, 64'h0000000000000000,
        64'h00000000ffffffff, 64'hffffffffffffffff};
    localparam logic [LIMB_W-1:0] NINV_RESET = 64'h0000000000000001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOD_LIMB0 = 3'd0,
        CFG_MOD_LIMB1 = 3'd1,
        CFG_MOD_LIMB2 = 3'd2,
        CFG_MOD_LIMB3 = 3'd3,
        CFG_NEG_INV   = 3'd4
    } cfg_idx_t;

    // Operands traveling alongside the accumulator
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } opnd_t;

endpackage

// ===== hw/rtl/mmc_mulacc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_mulacc
// Three-stage sum = acc + x * y, x one limb, y four limbs, 32x32 partials.
// ----------------------------------------------------------------------------
module mmc_mulacc
    import mmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [LIMB_W-1:0] x,
    input  logic [WORD_W-1:0] y,
    input  logic [ACC_W-1:0]  acc_in,
    input  opnd_t             side_in,
    output logic              out_valid,
    output logic [ACC_W-1:0]  sum,
    output opnd_t             side_out
);

    localparam int NH  = WORD_W / HALF_W;
    localparam int S_W = WORD_W + HALF_W + 1;

    logic [LIMB_W-1:0] pp_next [2][NH];
    logic [LIMB_W-1:0] pp_reg  [2][NH];
    logic [ACC_W-1:0]  acc1_reg, acc2_reg, sum_reg, sum_next;
    opnd_t             side1_reg, side2_reg, side3_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [WORD_W-1:0] even_w [2];
    logic [WORD_W-1:0] odd_w  [2];
    logic [S_W-1:0]    s_next [2];
    logic [S_W-1:0]    s_reg  [2];

    // Stage 1: 32x32 partial products
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < NH; j++)
            begin
                pp_next[i][j] = LIMB_W'(x[i*HALF_W +: HALF_W]) *
                                LIMB_W'(y[j*HALF_W +: HALF_W]);
            end
        end
    end

    // Stage 2: even and odd partials do not overlap; one add per x half
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            for (int k = 0; k < NUM_LIMBS; k++)
            begin
                even_w[i][k*LIMB_W +: LIMB_W] = pp_reg[i][2*k];
                odd_w[i][k*LIMB_W +: LIMB_W]  = pp_reg[i][2*k+1];
            end
            s_next[i] = S_W'(even_w[i]) + S_W'({odd_w[i], {HALF_W{1'b0}}});
        end
    end

    // Stage 3: merge both rows with the accumulator
    assign sum_next = acc2_reg + ACC_W'(s_reg[0]) + ACC_W'({s_reg[1], {HALF_W{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg    <= pp_next;
            acc1_reg  <= acc_in;
            side1_reg <= side_in;
            s_reg     <= s_next;
            acc2_reg  <= acc1_reg;
            side2_reg <= side1_reg;
            sum_reg   <= sum_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign sum       = sum_reg;
    assign side_out  = side3_reg;

endmodule

// ===== hw/rtl/mmc_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_round
// One CIOS round: t += a_i*b, u = t0*n0inv, t = (t + u*m) >> 64. Eight stages.
// ----------------------------------------------------------------------------
module mmc_round
    import mmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [LIMB_W-1:0] x,
    input  logic [T_W-1:0]    t_in,
    input  opnd_t             side_in,
    input  logic [WORD_W-1:0] modulus,
    input  logic [LIMB_W-1:0] neg_inv,
    output logic              out_valid,
    output logic [T_W-1:0]    t_out,
    output opnd_t             side_out
);

    logic              v_valid;
    logic [ACC_W-1:0]  v_sum;
    opnd_t             v_side;

    logic [LIMB_W-1:0] ll_next, lh_full, hl_full;
    logic [LIMB_W-1:0] ll_reg;
    logic [HALF_W-1:0] lh_reg, hl_reg, cross_sum;
    logic [ACC_W-1:0]  vacc1_reg, vacc2_reg;
    opnd_t             uside1_reg, uside2_reg;
    logic              uv1_reg, uv2_reg;
    logic [LIMB_W-1:0] u_next, u_reg;
    logic [ACC_W-1:0]  f_sum;

    // Multiply-accumulate of the operand row
    mmc_mulacc u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .x         (x),
        .y         (side_in.b),
        .acc_in    (ACC_W'(t_in)),
        .side_in   (side_in),
        .out_valid (v_valid),
        .sum       (v_sum),
        .side_out  (v_side)
    );

    // u stage 1: low-half products of t0 * n0inv
    assign ll_next = LIMB_W'(v_sum[HALF_W-1:0]) * LIMB_W'(neg_inv[HALF_W-1:0]);
    assign lh_full = LIMB_W'(v_sum[HALF_W-1:0]) * LIMB_W'(neg_inv[LIMB_W-1:HALF_W]);
    assign hl_full = LIMB_W'(v_sum[LIMB_W-1:HALF_W]) * LIMB_W'(neg_inv[HALF_W-1:0]);

    // u stage 2: combine, modulo 2^64
    assign cross_sum = lh_reg + hl_reg;
    assign u_next    = ll_reg + {cross_sum, {HALF_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uv1_reg <= 1'b0;
            uv2_reg <= 1'b0;
        end
        else if (en)
        begin
            uv1_reg <= v_valid;
            uv2_reg <= uv1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg     <= ll_next;
            lh_reg     <= lh_full[HALF_W-1:0];
            hl_reg     <= hl_full[HALF_W-1:0];
            vacc1_reg  <= v_sum;
            uside1_reg <= v_side;
            u_reg      <= u_next;
            vacc2_reg  <= vacc1_reg;
            uside2_reg <= uside1_reg;
        end
    end

    // Reduction row: t + u*m, low limb is zero and dropped
    mmc_mulacc u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (uv2_reg),
        .x         (u_reg),
        .y         (modulus),
        .acc_in    (vacc2_reg),
        .side_in   (uside2_reg),
        .out_valid (out_valid),
        .sum       (f_sum),
        .side_out  (side_out)
    );

    assign t_out = f_sum[LIMB_W +: T_W];

endmodule

// ===== hw/rtl/montgomery_mul_256_cios.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// montgomery_mul_256_cios
// 256-bit Montgomery multiplier r = a*b*2^-256 mod m, CIOS, 64-bit limbs.
// ----------------------------------------------------------------------------
// Fully pipelined: one operand pair is taken per cycle unless the output is
// held. Each round spends three stages on a_i*b, two on u = t0*n0inv and three
// on u*m, all built from 32x32 multipliers; four such rounds of eight stages
// feed one stage for the final conditional subtraction. The whole pipeline
// holds while a result waits on the output. Modulus and n0inv reset to P-256;
// the user must write them through the config port while idle; not enforced.
module montgomery_mul_256_cios
    import mmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [LIMB_W-1:0]    a_limb0,
    input  logic [LIMB_W-1:0]    a_limb1,
    input  logic [LIMB_W-1:0]    a_limb2,
    input  logic [LIMB_W-1:0]    a_limb3,
    input  logic [LIMB_W-1:0]    b_limb0,
    input  logic [LIMB_W-1:0]    b_limb1,
    input  logic [LIMB_W-1:0]    b_limb2,
    input  logic [LIMB_W-1:0]    b_limb3,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [LIMB_W-1:0]    r_limb0,
    output logic [LIMB_W-1:0]    r_limb1,
    output logic [LIMB_W-1:0]    r_limb2,
    output logic [LIMB_W-1:0]    r_limb3,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMB_W-1:0]    cfg_data
);

`include "montgomery_mul_256_cios_defines.svh"

    logic [WORD_W-1:0] modulus_reg;
    logic [LIMB_W-1:0] ninv_reg;
    logic              advance;

    logic              rnd_valid [NUM_LIMBS+1];
    logic [T_W-1:0]    rnd_t     [NUM_LIMBS+1];
    opnd_t             rnd_side  [NUM_LIMBS+1];

    logic [WORD_W-1:0] low_w;
    logic [WORD_W:0]   diff;
    logic              do_sub;
    logic [WORD_W-1:0] r_next, r_reg;
    logic              out_valid_reg;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
            ninv_reg    <= NINV_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MOD_LIMB0: modulus_reg[0*LIMB_W +: LIMB_W] <= cfg_data;
                CFG_MOD_LIMB1: modulus_reg[1*LIMB_W +: LIMB_W] <= cfg_data;
                CFG_MOD_LIMB2: modulus_reg[2*LIMB_W +: LIMB_W] <= cfg_data;
                CFG_MOD_LIMB3: modulus_reg[3*LIMB_W +: LIMB_W] <= cfg_data;
                CFG_NEG_INV:   ninv_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Whole pipeline moves unless a finished result is held
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Pipeline entry
    assign rnd_valid[0]  = in_valid;
    assign rnd_t[0]      = '0;
    assign rnd_side[0].a = {a_limb3, a_limb2, a_limb1, a_limb0};
    assign rnd_side[0].b = {b_limb3, b_limb2, b_limb1, b_limb0};

    // Four reduction rounds
    for (genvar k = 0; k < NUM_LIMBS; k++)
    begin : g_round
        mmc_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (rnd_valid[k]),
            .x         (rnd_side[k].a[k*LIMB_W +: LIMB_W]),
            .t_in      (rnd_t[k]),
            .side_in   (rnd_side[k]),
            .modulus   (modulus_reg),
            .neg_inv   (ninv_reg),
            .out_valid (rnd_valid[k+1]),
            .t_out     (rnd_t[k+1]),
            .side_out  (rnd_side[k+1])
        );
    end

    // Final conditional subtraction; borrow out of diff means low < m
    assign low_w  = rnd_t[NUM_LIMBS][WORD_W-1:0];
    assign diff   = {1'b0, low_w} - {1'b0, modulus_reg};
    assign do_sub = (|rnd_t[NUM_LIMBS][T_W-1:WORD_W]) || !diff[WORD_W];
    assign r_next = do_sub ? diff[WORD_W-1:0] : low_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= rnd_valid[NUM_LIMBS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r_reg <= r_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign r_limb0   = r_reg[0*LIMB_W +: LIMB_W];
    assign r_limb1   = r_reg[1*LIMB_W +: LIMB_W];
    assign r_limb2   = r_reg[2*LIMB_W +: LIMB_W];
    assign r_limb3   = r_reg[3*LIMB_W +: LIMB_W];

    // Checks
    `MMC_ASSERT_NEXT(a_fin_to_out, clk, rst_n,
        advance && rnd_valid[NUM_LIMBS], out_valid_reg)
    `MMC_ASSERT_NEXT(a_bubble_to_out, clk, rst_n,
        advance && !rnd_valid[NUM_LIMBS], !out_valid_reg)
    `MMC_ASSERT_NEXT(a_stall_holds, clk, rst_n,
        !advance, $stable(rnd_valid[NUM_LIMBS]) && $stable(rnd_t[NUM_LIMBS]))
    `MMC_ASSERT_SAME(a_stall_backs_up, clk, rst_n,
        out_valid_reg && !out_ready, !in_ready)

endmodule

// ===== tb/montgomery_mul_256_cios_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// montgomery_mul_256_cios_tb
// Self-checking bench for the pipelined 256-bit CIOS Montgomery multiplier.
// Operand pairs are pushed through a valid/ready port with random gaps while
// the result side stalls at random. Each accepted pair is run through a
// limb-level CIOS model in the bench, and each product is checked limb by
// limb in order. The modulus and n0inv are reprogrammed between phases:
// reset P-256, random odd moduli, extreme moduli, mismatched n0inv, even
// moduli, out-of-range operands and writes to spare register indexes.
// ----------------------------------------------------------------------------
module montgomery_mul_256_cios_tb;
    import mmc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = 3'd7;
    localparam int PIPE_LAT    = 40;     // 33-stage pipe plus margin
    localparam int STALL_LIMIT = 5000;   // cycles with no transfer at all
    localparam int HOLD_CYCLES = 200;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [LIMB_W-1:0]  a_limb0, a_limb1, a_limb2, a_limb3;
    logic [LIMB_W-1:0]  b_limb0, b_limb1, b_limb2, b_limb3;
    logic               out_valid;
    logic               out_ready;
    logic [LIMB_W-1:0]  r_limb0, r_limb1, r_limb2, r_limb3;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMB_W-1:0]  cfg_data;

    // Bench copy of the configuration
    logic [WORD_W-1:0]  modulus;
    logic [LIMB_W-1:0]  n0inv;

    logic [WORD_W-1:0]  product_q[$];
    int                 mismatches;
    int                 products_sent;
    int                 products_checked;
    int                 moduli_used;
    bit                 calm;          // no idling on either side
    bit                 hold_req;      // ask the receiver for a long hold-off
    int                 quiet_cycles;

    montgomery_mul_256_cios DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_limb0   (a_limb0),
        .a_limb1   (a_limb1),
        .a_limb2   (a_limb2),
        .a_limb3   (a_limb3),
        .b_limb0   (b_limb0),
        .b_limb1   (b_limb1),
        .b_limb2   (b_limb2),
        .b_limb3   (b_limb3),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .r_limb0   (r_limb0),
        .r_limb1   (r_limb1),
        .r_limb2   (r_limb2),
        .r_limb3   (r_limb3),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Montgomery product, limb by limb, with the same wrap and drop behavior
    // as the hardware for out-of-range operands or a bad n0inv.
    function automatic logic [WORD_W-1:0] mont_product(logic [WORD_W-1:0] a,
                                                       logic [WORD_W-1:0] b);
        logic [LIMB_W-1:0]   acc[6];
        logic [LIMB_W-1:0]   carry;
        logic [LIMB_W-1:0]   u;
        logic [2*LIMB_W-1:0] t;
        logic [LIMB_W:0]     s;
        logic [WORD_W-1:0]   low;
        for (int k = 0; k < 6; k++)
            acc[k] = '0;
        for (int i = 0; i < NUM_LIMBS; i++)
        begin
            // acc += a_i * b
            carry = '0;
            for (int j = 0; j < NUM_LIMBS; j++)
            begin
                t = {64'd0, a[i*LIMB_W +: LIMB_W]} * {64'd0, b[j*LIMB_W +: LIMB_W]}
                    + {64'd0, acc[j]} + {64'd0, carry};
                acc[j] = t[LIMB_W-1:0];
                carry  = t[2*LIMB_W-1:LIMB_W];
            end
            s = {1'b0, acc[4]} + {1'b0, carry};
            acc[4] = s[LIMB_W-1:0];
            acc[5] = {63'd0, s[LIMB_W]};
            // acc = (acc + u*m) >> 64
            u = acc[0] * n0inv;
            t = {64'd0, u} * {64'd0, modulus[LIMB_W-1:0]} + {64'd0, acc[0]};
            carry = t[2*LIMB_W-1:LIMB_W];
            for (int j = 1; j < NUM_LIMBS; j++)
            begin
                t = {64'd0, u} * {64'd0, modulus[j*LIMB_W +: LIMB_W]}
                    + {64'd0, acc[j]} + {64'd0, carry};
                acc[j-1] = t[LIMB_W-1:0];
                carry    = t[2*LIMB_W-1:LIMB_W];
            end
            s = {1'b0, acc[4]} + {1'b0, carry};
            acc[3] = s[LIMB_W-1:0];
            acc[4] = acc[5] + {63'd0, s[LIMB_W]};
            acc[5] = '0;
        end
        low = {acc[3], acc[2], acc[1], acc[0]};
        if (acc[4] != '0 || low >= modulus)
            low = low - modulus;
        return low;
    endfunction

    // -m^-1 mod 2^64 by Newton iteration (m0 odd)
    function automatic logic [LIMB_W-1:0] neg_inverse(logic [LIMB_W-1:0] m0);
        logic [LIMB_W-1:0] x;
        x = m0;
        for (int k = 0; k < 5; k++)
            x = x * (64'd2 - m0 * x);
        return -x;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        for (int k = 0; k < 8; k++)
            w[k*32 +: 32] = $urandom;
        return w;
    endfunction

    // Random operand, mostly below the modulus, biased toward edges now and then
    function automatic logic [WORD_W-1:0] rand_operand();
        int pick;
        pick = $urandom_range(19);
        if (modulus == '0)
            return rand_word();
        if (pick == 0)
            return '0;
        if (pick == 1)
            return modulus - 1;
        if (pick == 2)
            return rand_word() >> $urandom_range(255);
        return rand_word() % modulus;
    endfunction

    // One register write, bench copy updated alongside
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMB_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_MOD_LIMB0: modulus[0*LIMB_W +: LIMB_W] = value;
            CFG_MOD_LIMB1: modulus[1*LIMB_W +: LIMB_W] = value;
            CFG_MOD_LIMB2: modulus[2*LIMB_W +: LIMB_W] = value;
            CFG_MOD_LIMB3: modulus[3*LIMB_W +: LIMB_W] = value;
            CFG_NEG_INV:   n0inv = value;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for the pipe to drain, then program a new modulus and n0inv
    task automatic load_modulus(logic [WORD_W-1:0] m, logic [LIMB_W-1:0] ninv);
        wait_drained();
        write_reg(CFG_MOD_LIMB0, m[0*LIMB_W +: LIMB_W]);
        write_reg(CFG_MOD_LIMB1, m[1*LIMB_W +: LIMB_W]);
        write_reg(CFG_MOD_LIMB2, m[2*LIMB_W +: LIMB_W]);
        write_reg(CFG_MOD_LIMB3, m[3*LIMB_W +: LIMB_W]);
        write_reg(CFG_NEG_INV, ninv);
        end_writes();
        moduli_used++;
    endtask

    // Stop offering, then wait for every product to come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    // Offer one operand pair; expectation is queued on the transfer
    task automatic send_pair(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {a_limb3, a_limb2, a_limb1, a_limb0} <= a;
        {b_limb3, b_limb2, b_limb1, b_limb0} <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        product_q.push_back(mont_product(a, b));
        products_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_pair(rand_operand(), rand_operand());
    endtask

    // Edge operands under the reset P-256 modulus, including out-of-range ones
    task automatic test_reset_modulus();
        logic [WORD_W-1:0] ones;
        ones = '1;
        send_pair('0, '0);
        send_pair(256'd1, 256'd1);
        send_pair(modulus - 1, modulus - 1);
        send_pair(modulus - 1, 256'd1);
        send_pair(256'd1, modulus - 1);
        send_pair('0, modulus - 1);
        send_pair(ones, ones);
        send_pair(modulus, 256'd1);
        send_pair(modulus, modulus);
        send_pair(ones, 256'd1);
        send_pair(256'd1 << 255, 256'd2);
        send_pair({4{64'h5555555555555555}}, {4{64'haaaaaaaaaaaaaaaa}});
        send_random(400);
    endtask

    // Random odd moduli of assorted sizes with matching n0inv
    task automatic test_random_moduli();
        logic [WORD_W-1:0] m;
        for (int p = 0; p < 4; p++)
        begin
            m = rand_word() >> $urandom_range(p == 0 ? 0 : 200);
            m[0] = 1'b1;
            load_modulus(m, neg_inverse(m[LIMB_W-1:0]));
            calm = (p == 1);
            send_pair(m - 1, m - 1);
            send_random(100);
            calm = 1'b0;
        end
    endtask

    // Largest modulus, smallest useful moduli, and a modulus with only the top and bottom bits set
    task automatic test_extreme_moduli();
        logic [WORD_W-1:0] m;
        m = '1;
        load_modulus(m, neg_inverse(m[LIMB_W-1:0]));
        send_pair(m - 1, m - 1);
        send_random(100);
        m = 256'd3;
        load_modulus(m, neg_inverse(m[LIMB_W-1:0]));
        send_random(60);
        send_pair('1, '1);
        m = 256'd1;
        load_modulus(m, neg_inverse(m[LIMB_W-1:0]));
        for (int n = 0; n < 30; n++)
            send_pair(rand_word(), rand_word());
        m = (256'd1 << 255) | 256'd1;
        load_modulus(m, neg_inverse(m[LIMB_W-1:0]));
        send_random(80);
    endtask

    // Datapath behavior outside the contract: bad n0inv, even or zero
    // modulus, operands at or above m
    task automatic test_open_cases();
        logic [WORD_W-1:0] m;
        m = rand_word();
        m[0] = 1'b1;
        load_modulus(m, LIMB_W'(rand_word()));
        for (int n = 0; n < 50; n++)
            send_pair(rand_word(), rand_word());
        m = rand_word();
        m[0] = 1'b0;
        load_modulus(m, LIMB_W'(rand_word()));
        for (int n = 0; n < 50; n++)
            send_pair(rand_word(), rand_word());
        load_modulus('0, '0);
        for (int n = 0; n < 20; n++)
            send_pair(rand_word(), rand_word());
        load_modulus('1, '1);
        for (int n = 0; n < 30; n++)
            send_pair(rand_word(), rand_word());
    endtask

    // Writes to indexes past the register list must leave the config alone
    task automatic test_spare_index();
        logic [WORD_W-1:0] m;
        m = rand_word();
        m[0] = 1'b1;
        load_modulus(m, neg_inverse(m[LIMB_W-1:0]));
        write_reg(CFG_SPARE_IDX, LIMB_W'(rand_word()));
        write_reg(CFG_TOP_IDX, '0);
        end_writes();
        send_random(60);
    endtask

    // Receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_backpressure();
        load_modulus(MOD_RESET, NINV_RESET);
        hold_req = 1'b1;
        calm = 1'b1;
        send_random(120);
        calm = 1'b0;
        send_random(50);
    endtask

    // Receiver side: random stalls, or a counted hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // Product checker
    always @(posedge clk)
    begin
        logic [WORD_W-1:0] want;
        logic [WORD_W-1:0] got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {r_limb3, r_limb2, r_limb1, r_limb0};
            if (product_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected product %h", got);
            end
            else
            begin
                want = product_q.pop_front();
                products_checked++;
                for (int k = 0; k < NUM_LIMBS; k++)
                    if (got[k*LIMB_W +: LIMB_W] != want[k*LIMB_W +: LIMB_W])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: product %0d r_limb%0d expected %h got %h",
                                     products_checked, k, want[k*LIMB_W +: LIMB_W],
                                     got[k*LIMB_W +: LIMB_W]);
                    end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("montgomery_mul_256_cios verification failed");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        {a_limb3, a_limb2, a_limb1, a_limb0} = '0;
        {b_limb3, b_limb2, b_limb1, b_limb0} = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MOD_LIMB0;
        cfg_data = '0;
        modulus = MOD_RESET;
        n0inv = NINV_RESET;
        mismatches = 0;
        products_sent = 0;
        products_checked = 0;
        moduli_used = 1;
        calm = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_modulus();
        test_random_moduli();
        test_extreme_moduli();
        test_open_cases();
        test_spare_index();
        test_backpressure();
        stop_sending();
        wait_drained();

        $display("Checked %0d of %0d products over %0d modulus settings,",
                 products_checked, products_sent, moduli_used);
        $display("including out-of-range operands, bad n0inv and a long output stall.");
        if (mismatches == 0 && product_q.size() == 0)
            $display("montgomery_mul_256_cios verification clean");
        else
            $display("montgomery_mul_256_cios verification failed");
        $finish;
    end

endmodule
